@@ design/bda_pkg.sv @@
// Shared constants, codes and control structs for the button debounce/autorepeat block.
package bda_pkg;

    localparam int NUM_BUTTONS  = 9;
    localparam int MAX_REPEATS  = 8;
    localparam int RESULT_LIMIT = 8;

    localparam int BTN_W   = 4;
    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int IDX_W   = $clog2(NUM_BUTTONS);
    localparam int CNT_W   = $clog2(RESULT_LIMIT + 1);
    localparam int REP_W   = $clog2(MAX_REPEATS + 1);
    localparam int CFG_A_W = 3;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_HOLD     = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_PERIOD   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_RST_HOLD = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_MASK     = 3'd4;

    localparam logic [MS_W-1:0]        RST_DEBOUNCE = 16'd20;
    localparam logic [MS_W-1:0]        RST_HOLD     = 16'd400;
    localparam logic [MS_W-1:0]        RST_PERIOD   = 16'd100;
    localparam logic [MS_W-1:0]        RST_RST_HOLD = 16'd3000;
    localparam logic [NUM_BUTTONS-1:0] RST_MASK     = 9'd255;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REPEAT  = 2'd2,
        KIND_RESET   = 2'd3
    } t_kind;

    typedef struct packed {
        logic load;   // capture polled word
        logic deb;    // debounce step
        logic rep;    // emit one repeat
        logic rst;    // reset-button check
        logic fin;    // flush staged event as last
    } t_cmd;

    typedef struct packed {
        logic bad_idx;
        logic deb_ev;
        logic rep_due;
        logic rst_ev;
        logic can_gen;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

@@ design/bda_ctrl.sv @@
// Sequencer for one poll word: debounce, repeat loop, reset check, flush.
module bda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bda_pkg::t_sts i_sts,
    output bda_pkg::t_cmd o_cmd
);
    import bda_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEB  = 5'b00010,
        S_REP  = 5'b00100,
        S_RST  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEB;
                end
            end
            S_DEB: begin
                if (i_sts.bad_idx) begin
                    n_state = S_IDLE;
                end else if (!i_sts.deb_ev || i_sts.can_gen) begin
                    o_cmd.deb = 1'b1;
                    n_state   = S_REP;
                end
            end
            S_REP: begin
                if (!i_sts.rep_due) begin
                    n_state = S_RST;
                end else if (i_sts.can_gen) begin
                    o_cmd.rep = 1'b1;
                end
            end
            S_RST: begin
                if (!i_sts.rst_ev || i_sts.can_gen) begin
                    o_cmd.rst = 1'b1;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ design/bda_dp.sv @@
// Datapath: config registers, per-button state, event staging and output register.
module bda_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [bda_pkg::CFG_A_W-1:0]        i_cfg_index,
    input  logic [bda_pkg::MS_W-1:0]           i_cfg_data,
    input  logic [bda_pkg::BTN_W-1:0]          i_button_index,
    input  logic                               i_raw_level,
    input  logic [bda_pkg::TIME_W-1:0]         i_now_ms,
    input  bda_pkg::t_cmd                      i_cmd,
    output bda_pkg::t_sts                      o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bda_pkg::BTN_W-1:0]          o_event_button,
    output logic [1:0]                         o_event_kind,
    output logic [bda_pkg::TIME_W-1:0]         o_event_time_ms,
    output logic                               o_last
);
    import bda_pkg::*;

    localparam logic [CNT_W-1:0] LIMIT_C    = CNT_W'(RESULT_LIMIT);
    localparam logic [REP_W-1:0] MAX_REP_C  = REP_W'(MAX_REPEATS);
    localparam logic [BTN_W-1:0] LAST_BTN_C = BTN_W'(NUM_BUTTONS - 1);
    localparam logic [BTN_W-1:0] NUM_BTN_C  = BTN_W'(NUM_BUTTONS);

    // configuration
    logic [MS_W-1:0]        r_debounce, r_hold, r_period, r_rst_hold;
    logic [NUM_BUTTONS-1:0] r_mask;

    // per-button state
    logic              r_raw_seen [NUM_BUTTONS];
    logic              r_stable   [NUM_BUTTONS];
    logic [TIME_W-1:0] r_lct      [NUM_BUTTONS];
    logic [TIME_W-1:0] r_nrt      [NUM_BUTTONS];

    // reset button
    logic              r_hold_seen, r_fired;
    logic [TIME_W-1:0] r_hst;

    // current word
    logic [BTN_W-1:0]  r_b;
    logic              r_raw;
    logic [TIME_W-1:0] r_now;
    logic [CNT_W-1:0]  r_n;
    logic [REP_W-1:0]  r_reps;

    // staged event, held back until we know whether it is the last one
    logic  r_pend_valid;
    t_kind r_pend_kind;

    logic              r_out_valid;
    logic [BTN_W-1:0]  r_out_btn;
    t_kind             r_out_kind;
    logic [TIME_W-1:0] r_out_time;
    logic              r_out_last;

    logic [IDX_W-1:0]  idx;
    logic              cur_seen, cur_stable;
    logic [TIME_W-1:0] cur_lct, cur_nrt;
    logic              raw_chg;
    logic [TIME_W-1:0] lct_new, deb_dt, rep_dt, hold_dt;
    logic              out_free, push, gen;
    t_kind             gen_kind;

    assign idx        = r_b[IDX_W-1:0];
    assign cur_seen   = r_raw_seen[idx];
    assign cur_stable = r_stable[idx];
    assign cur_lct    = r_lct[idx];
    assign cur_nrt    = r_nrt[idx];

    assign raw_chg = (r_raw != cur_seen);
    assign lct_new = raw_chg ? r_now : cur_lct;
    assign deb_dt  = r_now - lct_new;
    assign rep_dt  = r_now - cur_nrt;
    assign hold_dt = r_now - r_hst;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.bad_idx    = (r_b >= NUM_BTN_C);
        o_sts.deb_ev     = (deb_dt >= {{(TIME_W-MS_W){1'b0}}, r_debounce})
                           && (cur_stable != r_raw);
        // signed wrap-safe check: due when the difference is non-negative
        o_sts.rep_due    = r_mask[idx] && cur_stable && (r_reps < MAX_REP_C)
                           && (r_n < LIMIT_C) && !rep_dt[TIME_W-1];
        o_sts.rst_ev     = (r_b == LAST_BTN_C) && cur_stable && r_hold_seen && !r_fired
                           && (hold_dt >= {{(TIME_W-MS_W){1'b0}}, r_rst_hold})
                           && (r_n < LIMIT_C);
        o_sts.can_gen    = !r_pend_valid || out_free;
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = out_free;
    end

    always_comb begin
        gen      = 1'b0;
        gen_kind = KIND_REPEAT;
        priority if (i_cmd.deb && o_sts.deb_ev) begin
            gen      = 1'b1;
            gen_kind = r_raw ? KIND_PRESS : KIND_RELEASE;
        end else if (i_cmd.rep) begin
            gen      = 1'b1;
            gen_kind = KIND_REPEAT;
        end else if (i_cmd.rst && o_sts.rst_ev) begin
            gen      = 1'b1;
            gen_kind = KIND_RESET;
        end else begin
            gen = 1'b0;
        end
    end

    assign push = r_pend_valid && (gen || i_cmd.fin);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= RST_DEBOUNCE;
            r_hold     <= RST_HOLD;
            r_period   <= RST_PERIOD;
            r_rst_hold <= RST_RST_HOLD;
            r_mask     <= RST_MASK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_debounce <= i_cfg_data;
                REG_HOLD:     r_hold     <= i_cfg_data;
                REG_PERIOD:   r_period   <= i_cfg_data;
                REG_RST_HOLD: r_rst_hold <= i_cfg_data;
                REG_MASK:     r_mask     <= i_cfg_data[NUM_BUTTONS-1:0];
                default: ;
            endcase
        end
    end

    // word capture and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b   <= i_button_index;
            r_raw <= i_raw_level;
            r_now <= i_now_ms;
        end
        if (!i_rst_n) begin
            r_n    <= '0;
            r_reps <= '0;
        end else if (i_cmd.load) begin
            r_n    <= '0;
            r_reps <= '0;
        end else begin
            if (gen) begin
                r_n <= r_n + CNT_W'(1);
            end
            if (i_cmd.rep) begin
                r_reps <= r_reps + REP_W'(1);
            end
        end
    end

    // per-button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_raw_seen[i] <= 1'b0;
                r_stable[i]   <= 1'b0;
                r_lct[i]      <= '0;
                r_nrt[i]      <= '0;
            end
        end else if (i_cmd.deb) begin
            r_raw_seen[idx] <= r_raw;
            r_lct[idx]      <= lct_new;
            if (o_sts.deb_ev) begin
                r_stable[idx] <= r_raw;
                r_nrt[idx]    <= r_raw ? (r_now + {{(TIME_W-MS_W){1'b0}}, r_hold}) : '0;
            end
        end else if (i_cmd.rep) begin
            r_nrt[idx] <= cur_nrt + {{(TIME_W-MS_W){1'b0}}, r_period};
        end
    end

    // reset-button hold tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_seen <= 1'b0;
            r_fired     <= 1'b0;
            r_hst       <= '0;
        end else if (i_cmd.rst && (r_b == LAST_BTN_C)) begin
            priority if (!cur_stable) begin
                r_hold_seen <= 1'b0;
                r_fired     <= 1'b0;
                r_hst       <= '0;
            end else if (!r_hold_seen) begin
                r_hold_seen <= 1'b1;
                r_fired     <= 1'b0;
                r_hst       <= r_now;
            end else if (o_sts.rst_ev) begin
                r_fired <= 1'b1;
            end
        end
    end

    // staging slot and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (gen) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.fin) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (gen) begin
            r_pend_kind <= gen_kind;
        end
        if (push) begin
            r_out_btn  <= r_b;
            r_out_kind <= r_pend_kind;
            r_out_time <= r_now;
            r_out_last <= i_cmd.fin;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_button  = r_out_btn;
    assign o_event_kind    = r_out_kind;
    assign o_event_time_ms = r_out_time;
    assign o_last          = r_out_last;

endmodule

@@ design/button_debounce_autorepeat_unit.sv @@
// After a word is accepted the sequencer steps through debounce, the repeat loop (one step
// per repeat, up to 8), the reset check and the flush, then returns to idle; the last
// event enters the output register as it returns. A new word is taken only in idle, so
// words do not overlap; a word with an out-of-range button index returns to idle from debounce.
// Events leave through an output register; a stalled output holds the sequencer.
// Synchronous active-low reset: all buttons released, times zero, registers at defaults.
// Top level: debounce and typematic repeat for nine buttons, reset button last.
module button_debounce_autorepeat_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bda_pkg::CFG_A_W-1:0] i_cfg_index,
    input  logic [bda_pkg::MS_W-1:0]    i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bda_pkg::BTN_W-1:0]   i_button_index,
    input  logic                        i_raw_level,
    input  logic [bda_pkg::TIME_W-1:0]  i_now_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bda_pkg::BTN_W-1:0]   o_event_button,
    output logic [1:0]                  o_event_kind,
    output logic [bda_pkg::TIME_W-1:0]  o_event_time_ms,
    output logic                        o_last
);
    import bda_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bda_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_button_index  (i_button_index),
        .i_raw_level     (i_raw_level),
        .i_now_ms        (i_now_ms),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_button  (o_event_button),
        .o_event_kind    (o_event_kind),
        .o_event_time_ms (o_event_time_ms),
        .o_last          (o_last)
    );

endmodule
